@@ hw/rtl/pidc_pkg.sv @@
// Shared types, constants and helper functions of the PID step block.
`default_nettype none

package pidc_pkg;

  // Fixed-point format of all values and the width of the internal stores.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int LIM_W     = DATA_W - 1;

  // Shared multiplier: one signed operand one bit wider than a word (the
  // error difference), one word-wide signed operand.
  localparam int MUL_A_W = DATA_W + 1;
  localparam int MUL_B_W = DATA_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // The accumulator holds a sum of three saturated words.
  localparam int ACC_W = DATA_W + 2;

  // Gains whose magnitude exceeds about 0.001 count as active.
  localparam int GAIN_TH = (1 << FRAC_BITS) / 1000;

  // Stream and register port geometry.
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = CFG_AW - 2;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_LOAD   = 2'd2
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_STEP_T   = 3'd3,
    REG_STEP_R   = 3'd4,
    REG_INT_LIM  = 3'd5,
    REG_OUT_LIM  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MSEL_DERIV,
    MSEL_INT,
    MSEL_PROP,
    MSEL_GD,
    MSEL_GI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    STORE_HOLD,
    STORE_COMMIT,
    STORE_CLEAR,
    STORE_LOAD
  } store_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MISC,
    ST_ISS_D,
    ST_ISS_I,
    ST_ISS_P,
    ST_ISS_GD,
    ST_INT,
    ST_ISS_GI,
    ST_ADD_D,
    ST_WAIT,
    ST_ADD_I,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] gain_p;
    logic [DATA_W-1:0] gain_i;
    logic [DATA_W-1:0] gain_d;
    logic [LIM_W-1:0]  step_time;
    logic [LIM_W-1:0]  step_rate;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  output_limit;
  } pidc_cfg_t;

  typedef struct packed {
    logic      capture;
    logic      err_ld;
    mul_sel_t  mul_sel;
    store_op_t store_op;
    acc_op_t   acc_op;
    logic      out_ld;
  } pidc_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       commit;
    logic       out_free;
  } pidc_sts_t;

  // Sign-extend a word to accumulator width.
  function automatic logic [ACC_W-1:0] ext_w(input logic [DATA_W-1:0] x);
    return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  // Saturate an accumulator-width value to a signed word.
  function automatic logic [DATA_W-1:0] sat_w(input logic [ACC_W-1:0] x);
    logic all_one;
    logic all_zero;
    all_one  = &x[ACC_W-1:DATA_W-1];
    all_zero = ~|x[ACC_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      return x[DATA_W-1:0];
    end else if (x[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Clamp a signed word to +-lim; a zero limit leaves the value alone.
  function automatic logic [DATA_W-1:0] clamp_mag(input logic [DATA_W-1:0] x,
                                                 input logic [LIM_W-1:0]  lim);
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] neg;
    xs  = $signed(x);
    pos = $signed({1'b0, lim});
    neg = -pos;
    if (lim == '0) begin
      return x;
    end else if (xs > pos) begin
      return pos;
    end else if (xs < neg) begin
      return neg;
    end else begin
      return x;
    end
  endfunction

  function automatic logic gain_big(input logic [DATA_W-1:0] g);
    logic signed [DATA_W-1:0] th;
    th = $signed(DATA_W'(GAIN_TH));
    return ($signed(g) > th) || ($signed(g) < -th);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pidc_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module pidc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidc_pkg::CFG_AW-1:0] paddr,
  input  logic [pidc_pkg::CFG_DW-1:0] pwdata,
  output logic [pidc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output pidc_pkg::pidc_cfg_t         cfg
);
  import pidc_pkg::*;

  pidc_cfg_t cfg_r;
  pidc_cfg_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:  cfg_nxt.gain_p         = pwdata[DATA_W-1:0];
        REG_GAIN_I:  cfg_nxt.gain_i         = pwdata[DATA_W-1:0];
        REG_GAIN_D:  cfg_nxt.gain_d         = pwdata[DATA_W-1:0];
        REG_STEP_T:  cfg_nxt.step_time      = pwdata[LIM_W-1:0];
        REG_STEP_R:  cfg_nxt.step_rate      = pwdata[LIM_W-1:0];
        REG_INT_LIM: cfg_nxt.integral_limit = pwdata[LIM_W-1:0];
        REG_OUT_LIM: cfg_nxt.output_limit   = pwdata[LIM_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:  prdata = cfg_r.gain_p;
      REG_GAIN_I:  prdata = cfg_r.gain_i;
      REG_GAIN_D:  prdata = cfg_r.gain_d;
      REG_STEP_T:  prdata = {1'b0, cfg_r.step_time};
      REG_STEP_R:  prdata = {1'b0, cfg_r.step_rate};
      REG_INT_LIM: prdata = {1'b0, cfg_r.integral_limit};
      REG_OUT_LIM: prdata = {1'b0, cfg_r.output_limit};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pidc_mul.sv @@
// Three-stage fixed-point multiplier with truncation and saturation.
`default_nettype none

module pidc_mul (
  input  logic                         clk,
  input  logic [pidc_pkg::MUL_A_W-1:0] op_a,
  input  logic [pidc_pkg::MUL_B_W-1:0] op_b,
  output logic [pidc_pkg::DATA_W-1:0]  res
);
  import pidc_pkg::*;

  localparam int SH_W = PROD_W - FRAC_BITS;

  logic [MUL_A_W-1:0] mag_a_r;
  logic [MUL_B_W-1:0] mag_b_r;
  logic               neg1_r;
  logic [PROD_W-1:0]  prod_r;
  logic               neg2_r;
  logic [DATA_W-1:0]  res_r;

  logic [SH_W-1:0]    shifted;
  logic [DATA_W-1:0]  max_mag;
  logic [DATA_W-1:0]  mag;
  logic               over;

  // Work in sign and magnitude so that the shift truncates toward zero.
  always_ff @(posedge clk) begin
    mag_a_r <= op_a[MUL_A_W-1] ? (~op_a + MUL_A_W'(1)) : op_a;
    mag_b_r <= op_b[MUL_B_W-1] ? (~op_b + MUL_B_W'(1)) : op_b;
    neg1_r  <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
    prod_r  <= PROD_W'(mag_a_r) * PROD_W'(mag_b_r);
    neg2_r  <= neg1_r;
    res_r   <= neg2_r ? (~mag + DATA_W'(1)) : mag;
  end

  always_comb begin
    shifted = prod_r[PROD_W-1:FRAC_BITS];
    max_mag = neg2_r ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    over    = (|shifted[SH_W-1:DATA_W]) || (shifted[DATA_W-1:0] > max_mag);
    mag     = over ? max_mag : shifted[DATA_W-1:0];
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/pidc_datapath.sv @@
// Datapath: item registers, error and integral stores, accumulator, output word.
`default_nettype none

module pidc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pidc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [pidc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  pidc_pkg::pidc_cfg_t              cfg,
  input  pidc_pkg::pidc_cmd_t              cmd,
  output pidc_pkg::pidc_sts_t              sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pidc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pidc_pkg::*;

  logic [1:0]        act_r;
  logic [DATA_W-1:0] sp_r;
  logic [DATA_W-1:0] ms_r;
  logic              commit_r;
  logic [DATA_W-1:0] load_r;
  logic [DATA_W-1:0] err_r;
  logic [DATA_W-1:0] last_err_r;
  logic [DATA_W-1:0] last_err_nxt;
  logic [DATA_W-1:0] int_r;
  logic [DATA_W-1:0] int_nxt;
  logic [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] drive_r;
  logic              active_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DATA_W-1:0]  mul_res;
  logic [DATA_W-1:0]  err_nxt;
  logic [DATA_W-1:0]  int_acc;
  logic [DATA_W-1:0]  drive_fin;
  logic               active_fin;

  pidc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  assign err_nxt = sat_w(ext_w(sp_r) - ext_w(ms_r));

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_DERIV: begin
        mul_a = {err_r[DATA_W-1], err_r} - {last_err_r[DATA_W-1], last_err_r};
        mul_b = {1'b0, cfg.step_rate};
      end
      MSEL_INT: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = {1'b0, cfg.step_time};
      end
      MSEL_PROP: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = cfg.gain_p;
      end
      MSEL_GD: begin
        // A zero step time switches the derivative term off.
        mul_a = (cfg.step_time == '0) ? '0 : {mul_res[DATA_W-1], mul_res};
        mul_b = cfg.gain_d;
      end
      MSEL_GI: begin
        mul_a = {int_r[DATA_W-1], int_r};
        mul_b = cfg.gain_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign int_acc = clamp_mag(sat_w(ext_w(int_r) + ext_w(mul_res)), cfg.integral_limit);

  always_comb begin
    int_nxt      = int_r;
    last_err_nxt = last_err_r;
    unique case (cmd.store_op)
      STORE_HOLD: begin
        int_nxt = int_r;
      end
      STORE_COMMIT: begin
        int_nxt      = int_acc;
        last_err_nxt = err_r;
      end
      STORE_CLEAR: begin
        int_nxt      = '0;
        last_err_nxt = '0;
      end
      STORE_LOAD: begin
        int_nxt = load_r;
      end
      default: begin
        int_nxt = int_r;
      end
    endcase
  end

  assign drive_fin  = (act_r == ACT_UPDATE) ?
                      clamp_mag(sat_w(acc_r), cfg.output_limit) : '0;
  assign active_fin = gain_big(cfg.gain_p) | gain_big(cfg.gain_i) | gain_big(cfg.gain_d);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_tuser;
      sp_r     <= in_tdata[31:0];
      ms_r     <= in_tdata[63:32];
      commit_r <= in_tdata[64];
      load_r   <= in_tdata[96:65];
    end
    if (cmd.err_ld) begin
      err_r <= err_nxt;
    end
    unique case (cmd.acc_op)
      ACC_HOLD: acc_r <= acc_r;
      ACC_LOAD: acc_r <= ext_w(mul_res);
      ACC_ADD:  acc_r <= acc_r + ext_w(mul_res);
      default:  acc_r <= acc_r;
    endcase
    if (cmd.out_ld) begin
      drive_r  <= drive_fin;
      active_r <= active_fin;
    end
  end

  // The stores that reset clears: last error, integral and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      int_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_err_r  <= last_err_nxt;
      int_r       <= int_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.action   = act_r;
  assign sts.commit   = commit_r;
  assign sts.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, active_r, drive_r};

endmodule

`default_nettype wire

@@ hw/rtl/pidc_ctrl.sv @@
// Controller: fixed schedule of multiplier issues and accumulations per item.
`default_nettype none

module pidc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pidc_pkg::pidc_sts_t sts,
  output pidc_pkg::pidc_cmd_t cmd
);
  import pidc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Multiplier results appear once they have passed the multiplier's registers;
  // the schedule below lines every consumer up with that delay.
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.err_ld   = 1'b0;
    cmd.mul_sel  = MSEL_DERIV;
    cmd.store_op = STORE_HOLD;
    cmd.acc_op   = ACC_HOLD;
    cmd.out_ld   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_ld = 1'b1;
        state_nxt  = (sts.action == ACT_UPDATE) ? ST_ISS_D : ST_MISC;
      end
      ST_MISC: begin
        unique case (sts.action)
          ACT_CLEAR: cmd.store_op = STORE_CLEAR;
          ACT_LOAD:  cmd.store_op = STORE_LOAD;
          default:   cmd.store_op = STORE_HOLD;
        endcase
        state_nxt = ST_OUT;
      end
      ST_ISS_D: begin
        cmd.mul_sel = MSEL_DERIV;
        state_nxt   = ST_ISS_I;
      end
      ST_ISS_I: begin
        cmd.mul_sel = MSEL_INT;
        state_nxt   = ST_ISS_P;
      end
      ST_ISS_P: begin
        cmd.mul_sel = MSEL_PROP;
        state_nxt   = ST_ISS_GD;
      end
      ST_ISS_GD: begin
        cmd.mul_sel = MSEL_GD;
        state_nxt   = ST_INT;
      end
      ST_INT: begin
        cmd.store_op = sts.commit ? STORE_COMMIT : STORE_HOLD;
        state_nxt    = ST_ISS_GI;
      end
      ST_ISS_GI: begin
        cmd.mul_sel = MSEL_GI;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_ADD_D;
      end
      ST_ADD_D: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_ADD_I;
      end
      ST_ADD_I: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pid_step_with_clamps.sv @@
// Top level of the fixed-point PID step block with integral and output clamps.
//
// Usage: software writes the gains, step time, its reciprocal and the two clamp
// limits over the APB-style cfg_ port while the block is idle. Each word on the
// in_ stream is one action chosen by in_tuser: an update step, a clear of the
// error and integral stores, or a load of the integral store. Every word gives
// exactly one result word on the out_ stream: the drive value (zero for actions
// other than an update) and the flag saying whether any gain is significant.
//
// Schedule: an update word runs through the error, issue, integral, add and
// output states; a clear or load word runs through the error, store and output
// states. The next word is taken only after the last result has been loaded
// into the output register. Five products go through a single shared three-stage
// multiplier, and the chains from derivative to derivative-gain product and
// from integral to integral-gain product set the length of the update schedule.
//
// Reset (rst_n low at a clock edge) zeroes the configuration registers, the
// stored error and the integral, returns the controller to idle and empties the
// output register. The output register parts the two sides: a new word is
// accepted while a result waits, and the block stalls only in its last step if
// the previous result has still not been taken.
`default_nettype none

module pid_step_with_clamps (
  input  logic                             clk,
  input  logic                             rst_n,
  // APB-style configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pidc_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [pidc_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [pidc_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // setpoint [31:0], measured [63:32], commit_error [64], load_value [96:65]
  input  logic [pidc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [pidc_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive [31:0], active [32]
  output logic [pidc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pidc_pkg::*;

  pidc_cfg_t cfg;
  pidc_cmd_t cmd;
  pidc_sts_t sts;

  pidc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while full");

  // Loading the result register always presents a word next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_tvalid)
    else $error("loaded result not presented");

  // After a word is accepted the block is busy working on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again while busy");

  // Input capture only happens on an accepted word.
  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (in_tvalid && in_tready))
    else $error("item captured without handshake");

endmodule

`default_nettype wire
